// ===== hw/rtl/bol_pkg.sv =====
// Shared types, codes and constants for the bounded ordered list.
package bol_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = 7;
    localparam int VAL_W    = 32;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 3;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DELETE     = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd6;
    localparam logic [ACT_W-1:0] ACT_READ_ALL   = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // Counter operations.
    localparam logic [2:0] CNT_HOLD = 3'd0;
    localparam logic [2:0] CNT_LEN  = 3'd1;
    localparam logic [2:0] CNT_TGT1 = 3'd2;
    localparam logic [2:0] CNT_ZERO = 3'd3;
    localparam logic [2:0] CNT_INC  = 3'd4;
    localparam logic [2:0] CNT_DEC  = 3'd5;

    // Read address selects.
    localparam logic [1:0] RA_CNT_M1 = 2'd0;
    localparam logic [1:0] RA_CNT    = 2'd1;
    localparam logic [1:0] RA_TGT    = 2'd2;

    // Write-back of read data to a neighboring entry.
    localparam logic [1:0] WB_NONE = 2'd0;
    localparam logic [1:0] WB_UP   = 2'd1;
    localparam logic [1:0] WB_DOWN = 2'd2;

    // Result value selects.
    localparam logic [1:0] VS_ZERO = 2'd0;
    localparam logic [1:0] VS_VAL  = 2'd1;
    localparam logic [1:0] VS_RD   = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [VAL_W-1:0] value;
        logic [LEN_W-1:0]        position;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] value_out;
        logic [LEN_W-1:0]        found_position;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } out_t;

    typedef struct packed {
        logic              load_in;
        logic [2:0]        cnt_op;
        logic              rd_en;
        logic [1:0]        rd_sel;
        logic [1:0]        rd_wb;
        logic              wr_val;
        logic              cap_val;
        logic              cap_pos;
        logic              emit;
        logic [STAT_W-1:0] status;
        logic [1:0]        vsel;
        logic              fpos_en;
        logic              last;
        logic              len_inc;
        logic              len_dec;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             full;
        logic             empty;
        logic             ins_bad;
        logic             del_bad;
        logic             cnt_gt_tgt;
        logic             cnt_lt_len;
        logic             cnt_is_last;
        logic             match;
        logic             rd_vld;
        logic             out_free;
    } sts_t;

endpackage

// ===== hw/rtl/bol_dp.sv =====
// Datapath of the ordered list: element memory, length, counter and result register.
module bol_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  bol_pkg::in_t  s_data,
    input  bol_pkg::cmd_t cmd,
    output bol_pkg::sts_t sts,
    output logic          m_valid,
    input  logic          m_ready,
    output bol_pkg::out_t m_data
);

    logic signed [bol_pkg::VAL_W-1:0] mem [bol_pkg::CAPACITY];

    logic [bol_pkg::ACT_W-1:0]        action_reg;
    logic signed [bol_pkg::VAL_W-1:0] value_reg;
    logic [bol_pkg::LEN_W-1:0]        pos_reg;
    logic [bol_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [bol_pkg::LEN_W-1:0]        cnt_reg, cnt_next;
    logic signed [bol_pkg::VAL_W-1:0] rd_data_reg;
    logic [bol_pkg::IDX_W-1:0]        rd_addr_reg;
    logic                             rd_vld_reg;
    logic [1:0]                       wb_reg;
    logic signed [bol_pkg::VAL_W-1:0] val_reg;
    logic [bol_pkg::LEN_W-1:0]        fpos_reg;
    logic                             m_valid_reg;
    bol_pkg::out_t                    m_data_reg;

    logic [bol_pkg::LEN_W-1:0]        tgt;
    logic [bol_pkg::LEN_W-1:0]        rd_full;
    logic [bol_pkg::IDX_W-1:0]        rd_addr;
    logic                             pend_wb;
    logic                             we;
    logic [bol_pkg::IDX_W-1:0]        wa;
    logic signed [bol_pkg::VAL_W-1:0] wd;
    logic                             out_free;
    bol_pkg::out_t                    res;

    // Target index of the action, 0-based.
    always_comb begin
        case (action_reg)
            bol_pkg::ACT_PUSH_FRONT, bol_pkg::ACT_POP_FRONT: tgt = '0;
            bol_pkg::ACT_PUSH_BACK:  tgt = len_reg;
            bol_pkg::ACT_POP_BACK:   tgt = len_reg - bol_pkg::LEN_W'(1);
            default:                 tgt = pos_reg - bol_pkg::LEN_W'(1);
        endcase
    end

    always_comb begin
        case (cmd.cnt_op)
            bol_pkg::CNT_LEN:  cnt_next = len_reg;
            bol_pkg::CNT_TGT1: cnt_next = tgt + bol_pkg::LEN_W'(1);
            bol_pkg::CNT_ZERO: cnt_next = '0;
            bol_pkg::CNT_INC:  cnt_next = cnt_reg + bol_pkg::LEN_W'(1);
            bol_pkg::CNT_DEC:  cnt_next = cnt_reg - bol_pkg::LEN_W'(1);
            default:           cnt_next = cnt_reg;
        endcase
    end

    always_comb begin
        case (cmd.rd_sel)
            bol_pkg::RA_CNT_M1: rd_full = cnt_reg - bol_pkg::LEN_W'(1);
            bol_pkg::RA_CNT:    rd_full = cnt_reg;
            default:            rd_full = tgt;
        endcase
        rd_addr = rd_full[bol_pkg::IDX_W-1:0];
    end

    // A shifted entry is written back the cycle after its read; that takes the write port.
    assign pend_wb = rd_vld_reg && (wb_reg != bol_pkg::WB_NONE);
    assign we      = pend_wb || cmd.wr_val;
    assign wd      = pend_wb ? rd_data_reg : value_reg;

    always_comb begin
        if (pend_wb && (wb_reg == bol_pkg::WB_UP)) begin
            wa = rd_addr_reg + bol_pkg::IDX_W'(1);
        end else if (pend_wb) begin
            wa = rd_addr_reg - bol_pkg::IDX_W'(1);
        end else begin
            wa = tgt[bol_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        len_next = len_reg;
        if (cmd.len_inc) begin
            len_next = len_reg + bol_pkg::LEN_W'(1);
        end else if (cmd.len_dec) begin
            len_next = len_reg - bol_pkg::LEN_W'(1);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        res.status = cmd.status;
        case (cmd.vsel)
            bol_pkg::VS_VAL: res.value_out = val_reg;
            bol_pkg::VS_RD:  res.value_out = rd_data_reg;
            default:         res.value_out = '0;
        endcase
        res.found_position = cmd.fpos_en ? fpos_reg : '0;
        res.length         = len_next;
        res.last           = cmd.last;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg    <= len_next;
            rd_vld_reg <= cmd.rd_en;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        if (cmd.load_in) begin
            action_reg <= s_data.action;
            value_reg  <= s_data.value;
            pos_reg    <= s_data.position;
        end
        if (cmd.rd_en) begin
            rd_addr_reg <= rd_addr;
            wb_reg      <= cmd.rd_wb;
        end
        if (cmd.cap_val) begin
            val_reg <= rd_data_reg;
        end
        if (cmd.cap_pos) begin
            fpos_reg <= bol_pkg::LEN_W'(rd_addr_reg) + bol_pkg::LEN_W'(1);
        end
        if (cmd.emit) begin
            m_data_reg <= res;
        end
    end

    assign sts.action      = action_reg;
    assign sts.full        = len_reg >= bol_pkg::LEN_W'(bol_pkg::CAPACITY);
    assign sts.empty       = len_reg == '0;
    assign sts.ins_bad     = (pos_reg == '0) || (pos_reg > len_reg + bol_pkg::LEN_W'(1));
    assign sts.del_bad     = (pos_reg == '0) || (pos_reg > len_reg);
    assign sts.cnt_gt_tgt  = cnt_reg > tgt;
    assign sts.cnt_lt_len  = cnt_reg < len_reg;
    assign sts.cnt_is_last = (cnt_reg + bol_pkg::LEN_W'(1)) == len_reg;
    assign sts.match       = rd_vld_reg && (rd_data_reg == value_reg);
    assign sts.rd_vld      = rd_vld_reg;
    assign sts.out_free    = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/bol_ctrl.sv =====
// Controller state machine of the ordered list: sequences memory walks and results.
module bol_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bol_pkg::sts_t sts,
    output bol_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_UP     = 4'd2;
    localparam logic [3:0] S_PLACE  = 4'd3;
    localparam logic [3:0] S_DCAP   = 4'd4;
    localparam logic [3:0] S_DOWN   = 4'd5;
    localparam logic [3:0] S_SRCH   = 4'd6;
    localparam logic [3:0] S_RRD    = 4'd7;
    localparam logic [3:0] S_REMIT  = 4'd8;
    localparam logic [3:0] S_RESP   = 4'd9;

    logic [3:0]                  state_reg, state_next;
    logic [bol_pkg::STAT_W-1:0]  rsp_status_reg, rsp_status_next;
    logic [1:0]                  rsp_vsel_reg, rsp_vsel_next;
    logic                        rsp_fpos_reg, rsp_fpos_next;
    logic                        rsp_inc_reg, rsp_inc_next;
    logic                        rsp_dec_reg, rsp_dec_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        rsp_status_next = rsp_status_reg;
        rsp_vsel_next   = rsp_vsel_reg;
        rsp_fpos_next   = rsp_fpos_reg;
        rsp_inc_next    = rsp_inc_reg;
        rsp_dec_next    = rsp_dec_reg;

        cmd         = '0;
        cmd.cnt_op  = bol_pkg::CNT_HOLD;
        cmd.rd_sel  = bol_pkg::RA_CNT;
        cmd.rd_wb   = bol_pkg::WB_NONE;
        cmd.status  = bol_pkg::ST_OK;
        cmd.vsel    = bol_pkg::VS_ZERO;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE: begin
                rsp_status_next = bol_pkg::ST_OK;
                rsp_vsel_next   = bol_pkg::VS_ZERO;
                rsp_fpos_next   = 1'b0;
                rsp_inc_next    = 1'b0;
                rsp_dec_next    = 1'b0;
                case (sts.action)
                    bol_pkg::ACT_PUSH_FRONT, bol_pkg::ACT_PUSH_BACK,
                    bol_pkg::ACT_INSERT: begin
                        if (sts.full) begin
                            rsp_status_next = bol_pkg::ST_FULL;
                            state_next      = S_RESP;
                        end else if ((sts.action == bol_pkg::ACT_INSERT) && sts.ins_bad) begin
                            rsp_status_next = bol_pkg::ST_RANGE;
                            state_next      = S_RESP;
                        end else begin
                            cmd.cnt_op = bol_pkg::CNT_LEN;
                            state_next = S_UP;
                        end
                    end
                    bol_pkg::ACT_POP_FRONT, bol_pkg::ACT_POP_BACK,
                    bol_pkg::ACT_DELETE: begin
                        if (sts.empty) begin
                            rsp_status_next = bol_pkg::ST_EMPTY;
                            state_next      = S_RESP;
                        end else if ((sts.action == bol_pkg::ACT_DELETE) && sts.del_bad) begin
                            rsp_status_next = bol_pkg::ST_RANGE;
                            state_next      = S_RESP;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = bol_pkg::RA_TGT;
                            state_next = S_DCAP;
                        end
                    end
                    bol_pkg::ACT_SEARCH: begin
                        cmd.cnt_op = bol_pkg::CNT_ZERO;
                        state_next = S_SRCH;
                    end
                    default: begin
                        if (sts.empty) begin
                            rsp_status_next = bol_pkg::ST_EMPTY;
                            state_next      = S_RESP;
                        end else begin
                            cmd.cnt_op = bol_pkg::CNT_ZERO;
                            state_next = S_RRD;
                        end
                    end
                endcase
            end

            // Move entries up one place, from the tail down to the target.
            S_UP: begin
                if (sts.cnt_gt_tgt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bol_pkg::RA_CNT_M1;
                    cmd.rd_wb  = bol_pkg::WB_UP;
                    cmd.cnt_op = bol_pkg::CNT_DEC;
                end else begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE: begin
                cmd.wr_val   = 1'b1;
                rsp_inc_next = 1'b1;
                state_next   = S_RESP;
            end

            S_DCAP: begin
                cmd.cap_val = 1'b1;
                cmd.cnt_op  = bol_pkg::CNT_TGT1;
                state_next  = S_DOWN;
            end

            // Move entries above the target down one place.
            S_DOWN: begin
                if (sts.cnt_lt_len) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bol_pkg::RA_CNT;
                    cmd.rd_wb  = bol_pkg::WB_DOWN;
                    cmd.cnt_op = bol_pkg::CNT_INC;
                end else begin
                    rsp_vsel_next = bol_pkg::VS_VAL;
                    rsp_dec_next  = 1'b1;
                    state_next    = S_RESP;
                end
            end

            // The compare runs one entry behind the read.
            S_SRCH: begin
                if (sts.match) begin
                    cmd.cap_pos   = 1'b1;
                    rsp_fpos_next = 1'b1;
                    state_next    = S_RESP;
                end else if (sts.cnt_lt_len) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bol_pkg::RA_CNT;
                    cmd.cnt_op = bol_pkg::CNT_INC;
                end else if (!sts.rd_vld) begin
                    rsp_status_next = bol_pkg::ST_NOTFOUND;
                    state_next      = S_RESP;
                end
            end

            S_RRD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bol_pkg::RA_CNT;
                state_next = S_REMIT;
            end

            S_REMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.vsel   = bol_pkg::VS_RD;
                    cmd.last   = sts.cnt_is_last;
                    cmd.cnt_op = bol_pkg::CNT_INC;
                    state_next = sts.cnt_is_last ? S_IDLE : S_RRD;
                end
            end

            S_RESP: begin
                if (sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.status  = rsp_status_reg;
                    cmd.vsel    = rsp_vsel_reg;
                    cmd.fpos_en = rsp_fpos_reg;
                    cmd.last    = 1'b1;
                    cmd.len_inc = rsp_inc_reg;
                    cmd.len_dec = rsp_dec_reg;
                    state_next  = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_status_reg <= rsp_status_next;
        rsp_vsel_reg   <= rsp_vsel_next;
        rsp_fpos_reg   <= rsp_fpos_next;
        rsp_inc_reg    <= rsp_inc_next;
        rsp_dec_reg    <= rsp_dec_next;
    end

endmodule

// ===== hw/rtl/bounded_ordered_list_top.sv =====
// Top level of the bounded ordered list: controller plus datapath.
//
// The s_ channel takes one action per transfer (push front/back, insert,
// pop front/back, delete, search, read all) with a value and a 1-based
// position. The m_ channel returns results; every action gives one result
// except read all on a non-empty list, which gives one per stored element
// with last set on the final one. Both channels use valid/ready handshakes.
// One action is worked on at a time. Elements sit in a single-port-style
// memory with one write and one registered read per cycle, so inserts,
// deletes and searches walk entries one per cycle, moving or comparing up
// to the capacity of 16 entries. The next action is accepted only once the
// result of the last one has been registered. Read all reads each element and
// then emits it, one element after another. The result register lets the final
// result wait for the receiver while the next action is accepted; a stalled
// receiver holds m_data steady and stops further progress once a new result
// is ready.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; memory contents are not cleared.
module bounded_ordered_list_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bol_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bol_pkg::out_t m_data
);

    bol_pkg::cmd_t cmd;
    bol_pkg::sts_t sts;

    bol_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bol_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== tb/bounded_ordered_list_top_tb.sv =====
// Self-checking testbench for the bounded ordered list: directed corner cases, then random traffic.
`timescale 1ns / 100ps

module bounded_ordered_list_top_tb;

    class ordered_list_scoreboard;
        logic signed [bol_pkg::VAL_W-1:0] shadow_list[$];
        bol_pkg::out_t                    pending_results[$];
        int                               mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Applies one accepted action to the shadow list and queues the results it should give.
        function void note_action(bol_pkg::in_t item);
            bol_pkg::out_t res;
            int            n;
            int            pos;
            int            hit;
            n   = shadow_list.size();
            pos = item.position;
            res = '0;
            res.last = 1'b1;
            case (item.action)
                bol_pkg::ACT_PUSH_FRONT, bol_pkg::ACT_PUSH_BACK: begin
                    if (n >= bol_pkg::CAPACITY) begin
                        res.status = bol_pkg::ST_FULL;
                    end else if (item.action == bol_pkg::ACT_PUSH_FRONT) begin
                        shadow_list.push_front(item.value);
                    end else begin
                        shadow_list.push_back(item.value);
                    end
                end
                bol_pkg::ACT_INSERT: begin
                    if (n >= bol_pkg::CAPACITY) begin
                        res.status = bol_pkg::ST_FULL;
                    end else if (pos < 1 || pos > n + 1) begin
                        res.status = bol_pkg::ST_RANGE;
                    end else begin
                        shadow_list.insert(pos - 1, item.value);
                    end
                end
                bol_pkg::ACT_POP_FRONT, bol_pkg::ACT_POP_BACK: begin
                    if (n == 0) begin
                        res.status = bol_pkg::ST_EMPTY;
                    end else if (item.action == bol_pkg::ACT_POP_FRONT) begin
                        res.value_out = shadow_list.pop_front();
                    end else begin
                        res.value_out = shadow_list.pop_back();
                    end
                end
                bol_pkg::ACT_DELETE: begin
                    if (n == 0) begin
                        res.status = bol_pkg::ST_EMPTY;
                    end else if (pos < 1 || pos > n) begin
                        res.status = bol_pkg::ST_RANGE;
                    end else begin
                        res.value_out = shadow_list[pos - 1];
                        shadow_list.delete(pos - 1);
                    end
                end
                bol_pkg::ACT_SEARCH: begin
                    hit = 0;
                    for (int i = n - 1; i >= 0; i--) begin
                        if (shadow_list[i] == item.value) begin
                            hit = i + 1;
                        end
                    end
                    if (hit == 0) begin
                        res.status = bol_pkg::ST_NOTFOUND;
                    end else begin
                        res.found_position = bol_pkg::LEN_W'(hit);
                    end
                end
                default: begin
                    if (n == 0) begin
                        res.status = bol_pkg::ST_EMPTY;
                    end else begin
                        // Read-out: one result per element, last only on the final one.
                        for (int i = 0; i < n; i++) begin
                            res.value_out = shadow_list[i];
                            res.length    = bol_pkg::LEN_W'(n);
                            res.last      = (i == n - 1);
                            pending_results.push_back(res);
                        end
                        return;
                    end
                end
            endcase
            res.length = bol_pkg::LEN_W'(shadow_list.size());
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [bol_pkg::VAL_W-1:0] want,
                                    logic [bol_pkg::VAL_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(bol_pkg::out_t got);
            bol_pkg::out_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("value_out", want.value_out, got.value_out);
            compare_field("found_position", want.found_position, got.found_position);
            compare_field("length", want.length, got.length);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    bol_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    bol_pkg::out_t m_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    ordered_list_scoreboard sb;

    bounded_ordered_list_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    // Holds valid and the payload until the transfer, then records the action.
    task automatic send_action(input bol_pkg::in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_action(item);
    endtask

    task automatic send_fields(input logic [bol_pkg::ACT_W-1:0] act,
                               input logic signed [bol_pkg::VAL_W-1:0] v,
                               input logic [bol_pkg::LEN_W-1:0] p);
        bol_pkg::in_t item;
        item.action   = act;
        item.value    = v;
        item.position = p;
        send_action(item);
    endtask

    // Any position the field can carry, in range or not.
    function automatic logic [bol_pkg::LEN_W-1:0] any_pos();
        return bol_pkg::LEN_W'($urandom_range(127));
    endfunction

    // Extremes and a small pool of values, so that searches see duplicates.
    function automatic logic signed [bol_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:          return 32'h8000_0000;
            1:          return 32'h7fff_ffff;
            2, 3, 4, 5: return $signed($urandom_range(6)) - 3;
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic signed [bol_pkg::VAL_W-1:0] search_value();
        int n;
        n = sb.shadow_list.size();
        if (n > 0 && $urandom_range(9) < 6) begin
            return sb.shadow_list[$urandom_range(n - 1)];
        end
        return pick_value();
    endfunction

    task automatic fill_burst(inout int sent);
        int n;
        n = sb.shadow_list.size();
        while (n < bol_pkg::CAPACITY) begin
            case ($urandom_range(2))
                0:       send_fields(bol_pkg::ACT_PUSH_FRONT, pick_value(), any_pos());
                1:       send_fields(bol_pkg::ACT_PUSH_BACK, pick_value(), any_pos());
                default: send_fields(bol_pkg::ACT_INSERT, pick_value(),
                                     bol_pkg::LEN_W'($urandom_range(1, n + 1)));
            endcase
            sent++;
            n = sb.shadow_list.size();
        end
        // Adds against a full list.
        send_fields(bol_pkg::ACT_W'(bol_pkg::ACT_PUSH_FRONT + $urandom_range(2)),
                    pick_value(), any_pos());
        send_fields(bol_pkg::ACT_SEARCH, search_value(), any_pos());
        send_fields(bol_pkg::ACT_READ_ALL, pick_value(), any_pos());
        sent += 3;
    endtask

    task automatic drain_burst(inout int sent);
        int n;
        n = sb.shadow_list.size();
        while (n > 0) begin
            case ($urandom_range(2))
                0:       send_fields(bol_pkg::ACT_POP_FRONT, pick_value(), any_pos());
                1:       send_fields(bol_pkg::ACT_POP_BACK, pick_value(), any_pos());
                default: send_fields(bol_pkg::ACT_DELETE, pick_value(),
                                     bol_pkg::LEN_W'($urandom_range(1, n)));
            endcase
            sent++;
            n = sb.shadow_list.size();
        end
        send_fields(bol_pkg::ACT_W'(bol_pkg::ACT_POP_FRONT + $urandom_range(2)),
                    pick_value(), any_pos());
        send_fields(bol_pkg::ACT_SEARCH, pick_value(), any_pos());
        sent += 2;
    endtask

    task automatic mixed_action(inout int sent);
        logic [bol_pkg::ACT_W-1:0] act;
        logic [bol_pkg::LEN_W-1:0] p;
        int                        n;
        n   = sb.shadow_list.size();
        act = bol_pkg::ACT_W'($urandom_range(7));
        if ($urandom_range(9) < 8) begin
            p = bol_pkg::LEN_W'($urandom_range(n + 1));
        end else begin
            p = any_pos();
        end
        if (act == bol_pkg::ACT_SEARCH) begin
            send_fields(act, search_value(), p);
        end else begin
            send_fields(act, pick_value(), p);
        end
        sent++;
    endtask

    initial begin
        int sent;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty-list behavior and position bounds.
        send_fields(bol_pkg::ACT_READ_ALL, 32'sd0, 7'd0);
        send_fields(bol_pkg::ACT_POP_FRONT, 32'sd0, 7'd0);
        send_fields(bol_pkg::ACT_POP_BACK, 32'sd0, 7'd0);
        send_fields(bol_pkg::ACT_DELETE, 32'sd0, 7'd1);
        send_fields(bol_pkg::ACT_SEARCH, 32'sd0, 7'd0);
        send_fields(bol_pkg::ACT_INSERT, 32'sd1, 7'd0);
        send_fields(bol_pkg::ACT_INSERT, 32'sd1, 7'd2);
        send_fields(bol_pkg::ACT_INSERT, 32'h8000_0000, 7'd1);
        send_fields(bol_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff, 7'd0);
        send_fields(bol_pkg::ACT_PUSH_BACK, -32'sd1, 7'h7f);
        send_fields(bol_pkg::ACT_INSERT, 32'sd0, 7'd4);
        send_fields(bol_pkg::ACT_INSERT, 32'sd5, 7'h7f);
        send_fields(bol_pkg::ACT_DELETE, 32'sd0, 7'd0);
        send_fields(bol_pkg::ACT_DELETE, 32'sd0, 7'd5);
        send_fields(bol_pkg::ACT_SEARCH, -32'sd1, 7'd0);
        send_fields(bol_pkg::ACT_SEARCH, 32'sd12345, 7'd0);
        send_fields(bol_pkg::ACT_READ_ALL, 32'sd0, 7'd0);
        send_fields(bol_pkg::ACT_DELETE, 32'sd0, 7'd2);
        send_fields(bol_pkg::ACT_INSERT, 32'h5555_aaaa, 7'd3);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            sent = 0;
            while (sent < 80) begin
                case ($urandom_range(9))
                    0, 1:    fill_burst(sent);
                    2:       drain_burst(sent);
                    default: mixed_action(sent);
                endcase
            end
        end
        s_valid <= 1'b0;

        while (sb.pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bol_pkg.sv
hw/rtl/bol_dp.sv
hw/rtl/bol_ctrl.sv
hw/rtl/bounded_ordered_list_top.sv
tb/bounded_ordered_list_top_tb.sv
